FILE: hdl/bau_pkg.sv
// Shared types and constants of the block adaptive bit unscrambler.
package bau_pkg;

  localparam int MaxBlockDef = 64;
  localparam int BlockSizeW = 7;
  localparam logic [BlockSizeW-1:0] BlockSizeReset = 7'd4;

  typedef struct packed {
    logic in_bit;
    logic line_start;
  } in_item_t;

  typedef struct packed {
    logic out_bit;
    logic block_last;
  } out_item_t;

  typedef enum logic [1:0] {
    RuleAll    = 2'd0,
    RuleSecond = 2'd1,
    RuleThird  = 2'd2
  } rule_e;

  typedef enum logic {
    StFill = 1'b0,
    StEmit = 1'b1
  } state_e;

  typedef struct packed {
    logic wr_en;
    logic wr_bit;
    logic rd_en;
  } mem_ctl_t;

  function automatic logic [1:0] rule_step(input rule_e rule);
    logic [1:0] step;
    unique case (rule)
      RuleSecond: step = 2'd2;
      RuleThird:  step = 2'd3;
      default:    step = 2'd1;
    endcase
    return step;
  endfunction

endpackage

FILE: hdl/bau_mem.sv
// Block bit store: one write port, one registered read port.
module bau_mem #(
  parameter int MaxBlock = bau_pkg::MaxBlockDef,
  localparam int AW = (MaxBlock > 1) ? $clog2(MaxBlock) : 1
) (
  input  logic             clk_i,
  input  bau_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [AW-1:0]    raddr_i,
  output logic             rbit_o
);

  logic mem [MaxBlock];
  logic rbit_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= ctl_i.wr_bit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rbit_q <= mem[raddr_i];
    end
  end

  assign rbit_o = rbit_q;

endmodule

FILE: hdl/bau_seq.sv
// Fill and emit sequencer with block decode and rule update.
module bau_seq #(
  parameter int MaxBlock = bau_pkg::MaxBlockDef,
  localparam int AW = (MaxBlock > 1) ? $clog2(MaxBlock) : 1,
  localparam int CW = $clog2(MaxBlock + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CW-1:0]      size_i,
  input  logic               cfg_wr_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bau_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bau_pkg::out_item_t out_item_o,
  output bau_pkg::mem_ctl_t  mem_ctl_o,
  output logic [AW-1:0]      mem_waddr_o,
  output logic [AW-1:0]      mem_raddr_o,
  input  logic               mem_rbit_i
);

  bau_pkg::state_e    state_q, state_d;
  bau_pkg::rule_e     rule_q, rule_eff, rule_next;
  logic [CW-1:0]      fill_q, idx, fill_next;
  logic [CW-1:0]      iss_cnt_q, ones_q, ones_new;
  logic [1:0]         phase_q, step;
  logic               rd_valid_q, rd_inv_q, rd_last_q;
  logic               out_valid_q;
  bau_pkg::out_item_t out_item_q;
  logic               emit_act, in_fire, blk_done, move, issue, inv_now, dec_bit;
  logic [CW:0]        ones_x2, size_x;

  assign in_fire = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_item_i.line_start || fill_q >= size_i) begin
      idx = '0;
    end else begin
      idx = fill_q;
    end
    fill_next = idx + CW'(1);
    rule_eff  = in_item_i.line_start ? bau_pkg::RuleAll : rule_q;
    blk_done  = in_fire && (fill_next == size_i);
  end

  // read side: memory output register feeds the output register
  assign move    = rd_valid_q && (!out_valid_q || !out_stall_i);
  assign issue   = emit_act && (iss_cnt_q < size_i) && (!rd_valid_q || move);
  assign step    = bau_pkg::rule_step(rule_q);
  assign inv_now = ((CW+2)'(step) <= (CW+2)'(size_i)) && (phase_q == step);
  assign dec_bit = mem_rbit_i ^ rd_inv_q;

  always_comb begin
    ones_new = ones_q + CW'(dec_bit);
    ones_x2  = {ones_new, 1'b0};
    size_x   = {1'b0, size_i};
    priority if (ones_x2 == size_x) begin
      rule_next = bau_pkg::RuleAll;
    end else if (ones_x2 < size_x) begin
      rule_next = bau_pkg::RuleSecond;
    end else begin
      rule_next = bau_pkg::RuleThird;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bau_pkg::StFill: begin
        if (blk_done) state_d = bau_pkg::StEmit;
      end
      bau_pkg::StEmit: begin
        if (move && rd_last_q) state_d = bau_pkg::StFill;
      end
      default: state_d = bau_pkg::StFill;
    endcase
  end

  always_comb begin
    unique case (state_q)
      bau_pkg::StEmit: begin
        in_stall_o = 1'b1;
        emit_act   = 1'b1;
      end
      default: begin
        in_stall_o = 1'b0;
        emit_act   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bau_pkg::StFill;
      rule_q      <= bau_pkg::RuleAll;
      fill_q      <= '0;
      iss_cnt_q   <= '0;
      phase_q     <= 2'd1;
      ones_q      <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_i) begin
        fill_q <= '0;
      end else if (in_fire) begin
        fill_q <= blk_done ? '0 : fill_next;
      end
      if (in_fire) begin
        rule_q <= rule_eff;
      end else if (move && rd_last_q) begin
        rule_q <= rule_next;
      end
      if (blk_done) begin
        iss_cnt_q <= '0;
        phase_q   <= 2'd1;
      end else if (issue) begin
        iss_cnt_q <= iss_cnt_q + CW'(1);
        phase_q   <= (phase_q == step) ? 2'd1 : phase_q + 2'd1;
      end
      if (blk_done) begin
        ones_q <= '0;
      end else if (move) begin
        ones_q <= ones_new;
      end
      if (issue) begin
        rd_valid_q <= 1'b1;
      end else if (move) begin
        rd_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_inv_q  <= inv_now;
      rd_last_q <= (iss_cnt_q + CW'(1)) == size_i;
    end
    if (move) begin
      out_item_q.out_bit    <= dec_bit;
      out_item_q.block_last <= rd_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_item_o       = out_item_q;
  assign mem_ctl_o.wr_en  = in_fire;
  assign mem_ctl_o.wr_bit = in_item_i.in_bit;
  assign mem_ctl_o.rd_en  = issue;
  assign mem_waddr_o      = idx[AW-1:0];
  assign mem_raddr_o      = iss_cnt_q[AW-1:0];

  a_no_fill_during_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !rd_valid_q)
    else $error("input transfer while a block read is in flight");

  a_last_ends_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && rd_last_q) |=> (state_q == bau_pkg::StFill))
    else $error("emission did not end after last bit");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_act |-> (iss_cnt_q <= size_i))
    else $error("read count past block size");

  a_ones_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_act |-> (ones_q <= iss_cnt_q))
    else $error("ones count exceeds bits read");

endmodule

FILE: hdl/block_adaptive_bit_unscrambler.sv
// Top level of the block adaptive bit unscrambler.
// After a block's last bit transfers, the sequencer enters its emit state; each result then
// passes the memory read register and the output register. Results leave one per cycle
// while out_stall_i is low; input is stalled while a block is emitted.
// Reset clears control state and rules, sets block_size to 4; store contents stay undefined.
module block_adaptive_bit_unscrambler #(
  parameter int MaxBlock = bau_pkg::MaxBlockDef,
  localparam int AW = (MaxBlock > 1) ? $clog2(MaxBlock) : 1,
  localparam int CW = $clog2(MaxBlock + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bau_pkg::BlockSizeW-1:0]    cfg_block_size_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bau_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bau_pkg::out_item_t                out_item_o
);

  logic [bau_pkg::BlockSizeW-1:0] block_size_q;
  logic [CW-1:0]                  size_eff;
  logic                           cfg_wr;
  bau_pkg::mem_ctl_t              mem_ctl;
  logic [AW-1:0]                  mem_waddr, mem_raddr;
  logic                           mem_rbit;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= bau_pkg::BlockSizeReset;
    end else if (cfg_wr) begin
      block_size_q <= cfg_block_size_i;
    end
  end

  always_comb begin
    priority if (block_size_q == '0) begin
      size_eff = CW'(1);
    end else if (32'(block_size_q) > MaxBlock) begin
      size_eff = CW'(MaxBlock);
    end else begin
      size_eff = CW'(block_size_q);
    end
  end

  bau_seq #(
    .MaxBlock(MaxBlock)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .size_i     (size_eff),
    .cfg_wr_i   (cfg_wr),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .mem_ctl_o  (mem_ctl),
    .mem_waddr_o(mem_waddr),
    .mem_raddr_o(mem_raddr),
    .mem_rbit_i (mem_rbit)
  );

  bau_mem #(
    .MaxBlock(MaxBlock)
  ) u_mem (
    .clk_i  (clk_i),
    .ctl_i  (mem_ctl),
    .waddr_i(mem_waddr),
    .raddr_i(mem_raddr),
    .rbit_o (mem_rbit)
  );

endmodule

FILE: tb/block_adaptive_bit_unscrambler_tb.sv
// Self-checking testbench of the block adaptive bit unscrambler.
module block_adaptive_bit_unscrambler_tb;

  localparam int MaxBlk = bau_pkg::MaxBlockDef;
  localparam int CycleT = 20;
  localparam int NumDirRows = 26;
  localparam int NumSizes = 10;

  typedef enum logic {
    RowBit = 1'b0,
    RowCfg = 1'b1
  } row_kind_e;

  // typed_n != 0: the block completed by this row must decode to typed_bits, bit 0 first
  typedef struct packed {
    row_kind_e                      kind;
    logic [bau_pkg::BlockSizeW-1:0] size;
    logic                           in_bit;
    logic                           line_start;
    logic [2:0]                     typed_n;
    logic [3:0]                     typed_bits;
  } dir_row_t;

  dir_row_t dir_rows [NumDirRows] = '{
    '{RowBit, 7'd0, 1'b1, 1'b1, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b0, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b1, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b1, 1'b0, 3'd4, 4'b0010},
    '{RowBit, 7'd0, 1'b1, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b1, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b1, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b1, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b0, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b0, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b0, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b0, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b0, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b1, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b1, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b0, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b1, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b0, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b0, 1'b1, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b0, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b0, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b0, 1'b0, 3'd0, 4'b0000},
    '{RowCfg, 7'd0, 1'b0, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b0, 1'b1, 3'd1, 4'b0001},
    '{RowBit, 7'd0, 1'b1, 1'b0, 3'd0, 4'b0000},
    '{RowBit, 7'd0, 1'b0, 1'b0, 3'd0, 4'b0000}
  };

  logic [bau_pkg::BlockSizeW-1:0] phase_sizes [NumSizes] = '{
    7'd127, 7'd1, 7'd0, 7'd64, 7'd2, 7'd3, 7'd65, 7'd5, 7'd6, 7'd8
  };

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bau_pkg::BlockSizeW-1:0] cfg_size = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  bau_pkg::in_item_t              in_item = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  bau_pkg::out_item_t             out_item;

  // predictor state
  logic [bau_pkg::BlockSizeW-1:0] size_reg = bau_pkg::BlockSizeReset;
  logic                           blk_bits [MaxBlk];
  int unsigned                    blk_fill = 0;
  bau_pkg::rule_e                 next_rule = bau_pkg::RuleAll;
  bau_pkg::out_item_t             pending_bits [$];

  bit          idle_on = 1'b1;
  int          stall_left = 0;
  int unsigned bits_sent = 0;
  int unsigned bits_checked = 0;
  int unsigned size_writes = 0;
  int unsigned mismatches = 0;

  block_adaptive_bit_unscrambler #(
    .MaxBlock(MaxBlk)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_block_size_i(cfg_size),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .in_item_i       (in_item),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .out_item_o      (out_item)
  );

  always begin
    #(CycleT / 2) clk = 1'b1;
    #(CycleT / 2) clk = 1'b0;
  end

  function automatic int unsigned eff_block(input logic [bau_pkg::BlockSizeW-1:0] size);
    return (size == 0) ? 1 : (size > MaxBlk) ? MaxBlk : int'(size);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Collect one accepted bit; on a full block queue its decoded bits.
  function automatic void decode_bit(input bau_pkg::in_item_t item,
                                     input logic [2:0] typed_n,
                                     input logic [3:0] typed_bits);
    int unsigned        size, step, ones;
    logic               v;
    bau_pkg::out_item_t res;
    size = eff_block(size_reg);
    ones = 0;
    if (item.line_start) begin
      blk_fill = 0;
      next_rule = bau_pkg::RuleAll;
    end
    if (blk_fill >= size) blk_fill = 0;
    blk_bits[blk_fill] = item.in_bit;
    blk_fill++;
    if (blk_fill < size) return;
    case (next_rule)
      bau_pkg::RuleSecond: step = 2;
      bau_pkg::RuleThird:  step = 3;
      default:             step = 1;
    endcase
    for (int unsigned i = 0; i < size; i++) begin
      v = blk_bits[i] ^ (step <= size && (i + 1) % step == 0);
      ones += v;
      res.out_bit = v;
      res.block_last = (i + 1 == size);
      if (typed_n == 0) pending_bits.push_back(res);
    end
    for (int unsigned i = 0; i < typed_n; i++) begin
      res.out_bit = typed_bits[i];
      res.block_last = (i + 1 == typed_n);
      pending_bits.push_back(res);
    end
    if (ones * 2 == size) next_rule = bau_pkg::RuleAll;
    else if (ones * 2 < size) next_rule = bau_pkg::RuleSecond;
    else next_rule = bau_pkg::RuleThird;
    blk_fill = 0;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_bit(input bau_pkg::in_item_t item, input logic [2:0] typed_n,
                          input logic [3:0] typed_bits);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (in_stall);
    decode_bit(item, typed_n, typed_bits);
    bits_sent++;
    @(negedge clk);
  endtask

  task automatic write_size(input logic [bau_pkg::BlockSizeW-1:0] size);
    in_valid <= 1'b0;
    while (pending_bits.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_size <= size;
    do @(posedge clk); while (!cfg_ready);
    size_reg = size;
    blk_fill = 0;
    size_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver stalls at random in bursts
  always @(negedge clk) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    bau_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bits.size() == 0) begin
        report_mismatch($sformatf("unexpected result out_bit %b block_last %b",
                                  out_item.out_bit, out_item.block_last));
      end else begin
        want = pending_bits.pop_front();
        if (out_item.out_bit !== want.out_bit)
          report_mismatch($sformatf("result %0d: out_bit %b, want %b",
                                    bits_checked, out_item.out_bit, want.out_bit));
        if (out_item.block_last !== want.block_last)
          report_mismatch($sformatf("result %0d: block_last %b, want %b",
                                    bits_checked, out_item.block_last, want.block_last));
      end
      bits_checked++;
    end
  end

  initial begin
    bau_pkg::in_item_t              item;
    logic [bau_pkg::BlockSizeW-1:0] size;
    int unsigned                    eff, n_items, ones_weight, n_phases;
    bit                             at_boundary;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < NumDirRows; r++) begin
      if (dir_rows[r].kind == RowCfg) begin
        write_size(dir_rows[r].size);
      end else begin
        item.in_bit = dir_rows[r].in_bit;
        item.line_start = dir_rows[r].line_start;
        send_bit(item, dir_rows[r].typed_n, dir_rows[r].typed_bits);
      end
    end

    ones_weight = 2;
    n_phases = NumSizes + 1;
    for (int p = 0; p < n_phases; p++) begin
      size = (p < NumSizes) ? phase_sizes[p] : 7'($urandom_range(1, 12));
      write_size(size);
      idle_on = (p == n_phases - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      eff = eff_block(size);
      n_items = (eff > 20) ? eff + 2 : 12;
      for (int unsigned k = 0; k < n_items; k++) begin
        at_boundary = (blk_fill == 0 || blk_fill >= eff);
        if (at_boundary) ones_weight = $urandom_range(0, 4);
        item.line_start = at_boundary ? ($urandom_range(0, 4) == 0)
                                      : ($urandom_range(0, 8 * eff - 1) == 0);
        item.in_bit = ($urandom_range(0, 3) < ones_weight);
        send_bit(item, 3'd0, 4'b0000);
      end
    end

    in_valid <= 1'b0;
    while (pending_bits.size() != 0) @(negedge clk);
    repeat (2 * MaxBlk + 4) @(negedge clk);
    $display("Sent %0d bits under %0d block size writes, including sizes 0, 1, 64 and 127.",
             bits_sent, size_writes);
    $display("Checked %0d decoded bits, %0d mismatches.", bits_checked, mismatches);
    if (mismatches == 0) begin
      $display("block_adaptive_bit_unscrambler_tb OK");
    end else begin
      $display("block_adaptive_bit_unscrambler_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(CycleT * 200_000);
    $display("Timeout at %0t", $time);
    $display("block_adaptive_bit_unscrambler_tb NOT OK");
    $finish;
  end

endmodule
